FILE: hdl/dbd_pkg.sv
package dbd_pkg;

	localparam int COORD_W     = 24;
	localparam int SCORE_W     = 16;
	localparam int CONF_W      = 16;
	localparam int PIX_W       = 14;
	localparam int CLS_W       = 2;
	localparam int MODE_W      = 2;
	localparam int CNT_W       = 3;
	localparam int INV_W       = 24;
	localparam int PAD_W       = 9;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam int MAX_CLASSES    = 4;
	localparam int MODEL_SIZE_DEF = 640;
	localparam int Q12_SHIFT      = 12;
	localparam int ONE_Q12        = 4096;
	localparam int EDGE_SHIFT     = 29;
	localparam int PIPE_STAGES    = 6;

	localparam logic [MODE_W-1:0] MODE_CLASS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RANGE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OBJ   = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_CONF_MIN,
		REG_CLASS_COUNT,
		REG_INVERSE_SCALE,
		REG_PAD_X,
		REG_PAD_Y,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} cfg_reg_t;

	localparam logic [CONF_W-1:0] RST_CONF_MIN       = 16'd16384;
	localparam logic [CNT_W-1:0]  RST_CLASS_COUNT    = 3'd1;
	localparam logic [INV_W-1:0]  RST_INVERSE_SCALE  = 24'd65536;
	localparam logic [PAD_W-1:0]  RST_PAD            = 9'd0;
	localparam logic [PIX_W-1:0]  RST_IMAGE_SIZE     = 14'd640;

	typedef struct packed {
		logic             ok;
		logic [PIX_W-1:0] lo;
		logic [PIX_W-1:0] len;
	} axis_res_t;

	typedef struct packed {
		logic              ok;
		logic [CONF_W-1:0] conf;
		logic [CLS_W-1:0]  cls;
	} score_res_t;

	typedef struct packed {
		logic [PIX_W-1:0]  left;
		logic [PIX_W-1:0]  top;
		logic [PIX_W-1:0]  width;
		logic [PIX_W-1:0]  height;
		logic [CONF_W-1:0] conf;
		logic [CLS_W-1:0]  cls;
	} box_t;

endpackage

FILE: hdl/dbd_axis.sv
module dbd_axis #(
	parameter int MODEL_INPUT_SIZE = dbd_pkg::MODEL_SIZE_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [dbd_pkg::COORD_W-1:0]  center,
	input  logic signed [dbd_pkg::COORD_W-1:0]  size,
	input  logic                                scale,
	input  logic        [dbd_pkg::PAD_W-1:0]    pad,
	input  logic        [dbd_pkg::INV_W-1:0]    inv,
	input  logic        [dbd_pkg::PIX_W-1:0]    limit,
	output dbd_pkg::axis_res_t                  res
);
	import dbd_pkg::*;

	localparam int PX_W = COORD_W + $clog2(MODEL_INPUT_SIZE + 1);
	localparam int D_W  = PX_W + 1;
	localparam int LO_W = 17;
	localparam int HI_W = D_W - LO_W;
	localparam int P_W  = D_W + INV_W;
	localparam int E_W  = P_W + 2;
	localparam int Q_W  = E_W - EDGE_SHIFT;

	logic signed [PX_W-1:0] cx, sx, pc, ps;
	logic signed [D_W-1:0]  pad_off;

	logic signed [D_W-1:0]  dc_s1, ds_s1;
	logic [LO_W+INV_W-1:0]  cl_s2, sl_s2;
	logic signed [HI_W+INV_W:0] ch_s2, sh_s2;
	logic signed [P_W-1:0]  c_s3, s_s3;
	logic signed [E_W-1:0]  elo_s4, ehi_s4;
	logic [PIX_W-1:0]       lo_s5, hi_s5;
	logic                   lo_over_s5, hi_nonpos_s5;
	axis_res_t              res_s6;

	logic signed [Q_W-1:0]  qlo, qhi;
	logic                   hi_big;

	always_comb begin
		cx = PX_W'(center);
		sx = PX_W'(size);
		pc = scale ? PX_W'(cx * MODEL_INPUT_SIZE) : cx;
		ps = scale ? PX_W'(sx * MODEL_INPUT_SIZE) : sx;
		pad_off = $signed({{(D_W - PAD_W - Q12_SHIFT){1'b0}}, pad, {Q12_SHIFT{1'b0}}});
	end

	// truncate toward zero
	always_comb begin
		qlo = Q_W'(elo_s4 >>> EDGE_SHIFT)
			+ Q_W'(elo_s4[E_W-1] && (|elo_s4[EDGE_SHIFT-1:0]));
		qhi = Q_W'(ehi_s4 >>> EDGE_SHIFT)
			+ Q_W'(ehi_s4[E_W-1] && (|ehi_s4[EDGE_SHIFT-1:0]));
		hi_big = !qhi[Q_W-1]
			&& ((|qhi[Q_W-2:PIX_W]) || (qhi[PIX_W-1:0] > limit));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s1 <= D_W'(pc) - pad_off;
			ds_s1 <= D_W'(ps);

			cl_s2 <= (LO_W+INV_W)'(dc_s1[LO_W-1:0]) * (LO_W+INV_W)'(inv);
			sl_s2 <= (LO_W+INV_W)'(ds_s1[LO_W-1:0]) * (LO_W+INV_W)'(inv);
			ch_s2 <= $signed(dc_s1[D_W-1:LO_W]) * $signed({1'b0, inv});
			sh_s2 <= $signed(ds_s1[D_W-1:LO_W]) * $signed({1'b0, inv});

			c_s3 <= (P_W'(ch_s2) <<< LO_W) + P_W'($signed({1'b0, cl_s2}));
			s_s3 <= (P_W'(sh_s2) <<< LO_W) + P_W'($signed({1'b0, sl_s2}));

			elo_s4 <= (E_W'(c_s3) <<< 1) - E_W'(s_s3);
			ehi_s4 <= (E_W'(c_s3) <<< 1) + E_W'(s_s3);

			lo_s5        <= qlo[Q_W-1] ? '0 : qlo[PIX_W-1:0];
			lo_over_s5   <= !qlo[Q_W-1] && (|qlo[Q_W-2:PIX_W]);
			hi_s5        <= hi_big ? limit : qhi[PIX_W-1:0];
			hi_nonpos_s5 <= qhi[Q_W-1] || (qhi == '0);

			res_s6.ok  <= !lo_over_s5 && !hi_nonpos_s5 && (hi_s5 > lo_s5);
			res_s6.lo  <= lo_s5;
			res_s6.len <= hi_s5 - lo_s5;
		end
	end

	assign res = res_s6;

endmodule

FILE: hdl/dbd_score.sv
module dbd_score (
	input  logic                                                 clk,
	input  logic                                                 en,
	input  logic [dbd_pkg::SCORE_W-1:0]                          objectness,
	input  logic [dbd_pkg::MAX_CLASSES-1:0][dbd_pkg::SCORE_W-1:0] scores,
	input  logic [dbd_pkg::CNT_W-1:0]                            class_count,
	input  logic [dbd_pkg::CONF_W-1:0]                           threshold,
	input  logic                                                 obj_mode,
	input  logic                                                 pre_ok,
	output dbd_pkg::score_res_t                                  res
);
	import dbd_pkg::*;

	logic [CNT_W-1:0]   n;
	logic [SCORE_W-1:0] best;
	logic [CLS_W-1:0]   cls;
	logic [2*SCORE_W-1:0] prod;

	logic [SCORE_W-1:0] best_s1, obj_s1;
	logic [CLS_W-1:0]   cls_s1;
	logic               obj_mode_s1, pre_ok_s1;
	logic [CONF_W-1:0]  conf_s2;
	logic [CLS_W-1:0]   cls_s2;
	logic               pre_ok_s2;
	score_res_t         res_s3, res_s4, res_s5, res_s6;

	always_comb begin
		n = (class_count > CNT_W'(MAX_CLASSES)) ? CNT_W'(MAX_CLASSES) : class_count;
		best = '0;
		cls = '0;
		for (int j = 0; j < MAX_CLASSES; j++) begin
			if ((CNT_W'(j) < n) && (scores[j] > best)) begin
				best = scores[j];
				cls = CLS_W'(j);
			end
		end
		prod = obj_s1 * best_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			best_s1     <= best;
			cls_s1      <= cls;
			obj_s1      <= objectness;
			obj_mode_s1 <= obj_mode;
			pre_ok_s1   <= pre_ok;

			if (obj_mode_s1) begin
				conf_s2 <= obj_s1;
				cls_s2  <= '0;
			end else begin
				conf_s2 <= prod[2*SCORE_W-1] ? '1 : prod[2*SCORE_W-2:SCORE_W-1];
				cls_s2  <= cls_s1;
			end
			pre_ok_s2 <= pre_ok_s1;

			res_s3.ok   <= pre_ok_s2 && (conf_s2 >= threshold);
			res_s3.conf <= conf_s2;
			res_s3.cls  <= cls_s2;

			res_s4 <= res_s3;
			res_s5 <= res_s4;
			res_s6 <= res_s5;
		end
	end

	assign res = res_s6;

endmodule

FILE: hdl/detection_box_decoder.sv
// Decodes one detector prediction per clock into a pixel box in the original
// image. Two axis lanes (x and y) each run a six-stage path: pixel scaling and
// padding removal, split 17x24 and 18x25 partial products against
// inverse_scale, recombination, edge sums, truncation with clamping, and the
// empty-box test. A score lane finds the best class and the confidence
// alongside them, and the merge stage keeps a box only when all three lanes
// pass. Throughput is one transaction per cycle while the skid entry is
// empty; a result is registered in the six lane stages and then in the
// output register. Dropped predictions produce no output transaction. An
// output register with a one-entry skid keeps the input open while one result
// waits; the input stalls only while the skid entry is occupied.
// Configuration takes effect immediately and should be written only when the
// pipeline is empty.
module detection_box_decoder #(
	parameter int MODEL_INPUT_SIZE = dbd_pkg::MODEL_SIZE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_en,
	input  logic [dbd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dbd_pkg::CFG_DATA_W-1:0]      cfg_data,

	input  logic                                pred_valid,
	output logic                                pred_ready,
	input  logic signed [dbd_pkg::COORD_W-1:0]  x_center,
	input  logic signed [dbd_pkg::COORD_W-1:0]  y_center,
	input  logic signed [dbd_pkg::COORD_W-1:0]  box_width,
	input  logic signed [dbd_pkg::COORD_W-1:0]  box_height,
	input  logic [dbd_pkg::SCORE_W-1:0]         objectness,
	input  logic [dbd_pkg::SCORE_W-1:0]         score_zero,
	input  logic [dbd_pkg::SCORE_W-1:0]         score_one,
	input  logic [dbd_pkg::SCORE_W-1:0]         score_two,
	input  logic [dbd_pkg::SCORE_W-1:0]         score_three,

	output logic                                box_valid,
	input  logic                                box_ready,
	output logic [dbd_pkg::PIX_W-1:0]           left,
	output logic [dbd_pkg::PIX_W-1:0]           top,
	output logic [dbd_pkg::PIX_W-1:0]           rect_width,
	output logic [dbd_pkg::PIX_W-1:0]           rect_height,
	output logic [dbd_pkg::CONF_W-1:0]          confidence,
	output logic [dbd_pkg::CLS_W-1:0]           best_class
);
	import dbd_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic [CONF_W-1:0] thr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [INV_W-1:0]  inv_q;
	logic [PAD_W-1:0]  pad_x_q, pad_y_q;
	logic [PIX_W-1:0]  img_w_q, img_h_q;

	logic signed [COORD_W-1:0] coord [4];
	logic all_unit, all_above, scale, pre_ok, obj_mode;
	logic en, accept, keep;
	logic [MAX_CLASSES-1:0][SCORE_W-1:0] scores;
	logic [PIPE_STAGES-1:0] vld_q;

	axis_res_t  x_res, y_res;
	score_res_t sc_res;
	box_t       new_box;
	box_t       out_q, skid_q;
	logic       out_v_q, skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CLASS;
			thr_q   <= RST_CONF_MIN;
			cnt_q   <= RST_CLASS_COUNT;
			inv_q   <= RST_INVERSE_SCALE;
			pad_x_q <= RST_PAD;
			pad_y_q <= RST_PAD;
			img_w_q <= RST_IMAGE_SIZE;
			img_h_q <= RST_IMAGE_SIZE;
		end else if (cfg_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODE:          mode_q  <= cfg_data[MODE_W-1:0];
				REG_CONF_MIN:      thr_q   <= cfg_data[CONF_W-1:0];
				REG_CLASS_COUNT:   cnt_q   <= cfg_data[CNT_W-1:0];
				REG_INVERSE_SCALE: inv_q   <= cfg_data[INV_W-1:0];
				REG_PAD_X:         pad_x_q <= cfg_data[PAD_W-1:0];
				REG_PAD_Y:         pad_y_q <= cfg_data[PAD_W-1:0];
				REG_IMAGE_WIDTH:   img_w_q <= cfg_data[PIX_W-1:0];
				REG_IMAGE_HEIGHT:  img_h_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coord[0] = x_center;
		coord[1] = y_center;
		coord[2] = box_width;
		coord[3] = box_height;
		all_unit  = 1'b1;
		all_above = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (coord[i] < 0 || coord[i] > COORD_W'(ONE_Q12))
				all_unit = 1'b0;
			if (coord[i] <= COORD_W'(ONE_Q12))
				all_above = 1'b0;
		end
		obj_mode = (mode_q == MODE_OBJ);
		scale = !(obj_mode && !all_unit);
		if (obj_mode)
			pre_ok = (objectness >= thr_q) && (all_unit || all_above);
		else
			pre_ok = (objectness >= thr_q) && ((mode_q != MODE_RANGE) || all_unit);
		scores = {score_three, score_two, score_one, score_zero};
	end

	assign en         = !skid_v_q;
	assign pred_ready = en;
	assign accept     = pred_valid && en;

	dbd_axis #(.MODEL_INPUT_SIZE(MODEL_INPUT_SIZE)) u_axis_x (
		.clk    (clk),
		.en     (en),
		.center (x_center),
		.size   (box_width),
		.scale  (scale),
		.pad    (pad_x_q),
		.inv    (inv_q),
		.limit  (img_w_q),
		.res    (x_res)
	);

	dbd_axis #(.MODEL_INPUT_SIZE(MODEL_INPUT_SIZE)) u_axis_y (
		.clk    (clk),
		.en     (en),
		.center (y_center),
		.size   (box_height),
		.scale  (scale),
		.pad    (pad_y_q),
		.inv    (inv_q),
		.limit  (img_h_q),
		.res    (y_res)
	);

	dbd_score u_score (
		.clk         (clk),
		.en          (en),
		.objectness  (objectness),
		.scores      (scores),
		.class_count (cnt_q),
		.threshold   (thr_q),
		.obj_mode    (obj_mode),
		.pre_ok      (pre_ok),
		.res         (sc_res)
	);

	// merge
	always_comb begin
		keep = vld_q[PIPE_STAGES-1] && sc_res.ok && x_res.ok && y_res.ok;
		new_box.left   = x_res.lo;
		new_box.top    = y_res.lo;
		new_box.width  = x_res.len;
		new_box.height = y_res.len;
		new_box.conf   = sc_res.conf;
		new_box.cls    = sc_res.cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en)
				vld_q <= {vld_q[PIPE_STAGES-2:0], accept};
			if (skid_v_q) begin
				if (box_ready) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end
			end else if (keep) begin
				if (!out_v_q || box_ready)
					out_v_q <= 1'b1;
				else
					skid_v_q <= 1'b1;
			end else if (box_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (box_ready)
				out_q <= skid_q;
		end else if (keep) begin
			if (!out_v_q || box_ready)
				out_q <= new_box;
			else
				skid_q <= new_box;
		end
	end

	assign box_valid   = out_v_q;
	assign left        = out_q.left;
	assign top         = out_q.top;
	assign rect_width  = out_q.width;
	assign rect_height = out_q.height;
	assign confidence  = out_q.conf;
	assign best_class  = out_q.cls;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output entry");

	a_skid_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !pred_ready)
		else $error("input open while skid entry is occupied");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(keep && !skid_v_q && out_v_q && !box_ready) |=> skid_v_q)
		else $error("kept box lost while output stalled");

	a_box_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (rect_width != '0) && (rect_height != '0))
		else $error("empty box delivered");

	a_box_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> ({1'b0, left} + {1'b0, rect_width} <= {1'b0, img_w_q})
			&& ({1'b0, top} + {1'b0, rect_height} <= {1'b0, img_h_q}))
		else $error("box exceeds image bounds");

endmodule

FILE: sim/dbd_box_checker.sv
module dbd_box_checker
	import dbd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       pred_valid,
	input  logic                       pred_ready,
	input  logic signed [COORD_W-1:0]  x_center,
	input  logic signed [COORD_W-1:0]  y_center,
	input  logic signed [COORD_W-1:0]  box_width,
	input  logic signed [COORD_W-1:0]  box_height,
	input  logic [SCORE_W-1:0]         objectness,
	input  logic [SCORE_W-1:0]         score_zero,
	input  logic [SCORE_W-1:0]         score_one,
	input  logic [SCORE_W-1:0]         score_two,
	input  logic [SCORE_W-1:0]         score_three,
	input  logic                       box_valid,
	input  logic                       box_ready,
	input  logic [PIX_W-1:0]           left,
	input  logic [PIX_W-1:0]           top,
	input  logic [PIX_W-1:0]           rect_width,
	input  logic [PIX_W-1:0]           rect_height,
	input  logic [CONF_W-1:0]          confidence,
	input  logic [CLS_W-1:0]           best_class,
	output int                         mismatches,
	output int                         boxes_owed
);

	localparam longint EDGE_DIV = longint'(1) << EDGE_SHIFT;
	localparam longint CONF_MAX = 65535;

	logic [MODE_W-1:0] mode;
	logic [CONF_W-1:0] min_conf;
	logic [CNT_W-1:0]  class_count;
	logic [INV_W-1:0]  inverse_scale;
	logic [PAD_W-1:0]  pad_x;
	logic [PAD_W-1:0]  pad_y;
	logic [PIX_W-1:0]  image_width;
	logic [PIX_W-1:0]  image_height;

	box_t expected_boxes[$];

	task automatic report(input string what, input longint got_v, input longint want_v);
		$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got_v, want_v);
		mismatches = mismatches + 1;
	endtask

	// one axis: center and size in Q12.12 model pixels -> clamped edge and extent
	function automatic bit decode_axis(input longint center, input longint size,
			input longint pad, input longint limit,
			output logic [PIX_W-1:0] lo_px, output logic [PIX_W-1:0] len_px);
		longint scale;
		longint c;
		longint s;
		longint lo;
		longint hi;
		scale = longint'(inverse_scale);
		c = (center - pad * ONE_Q12) * scale;
		s = size * scale;
		lo = (2 * c - s) / EDGE_DIV;
		hi = (2 * c + s) / EDGE_DIV;
		if (lo < 0) begin
			lo = 0;
		end
		if (hi > limit) begin
			hi = limit;
		end
		lo_px = lo[PIX_W-1:0];
		len_px = PIX_W'(hi - lo);
		return hi > lo;
	endfunction

	function automatic bit decode_prediction(input longint coord[4],
			input logic [SCORE_W-1:0] obj, input logic [SCORE_W-1:0] score[4],
			output box_t b);
		longint px[4];
		longint conf;
		longint best;
		bit unit_all;
		bit above_all;
		int n;
		logic [CLS_W-1:0] cls;
		unit_all = 1'b1;
		above_all = 1'b1;
		best = 0;
		cls = '0;
		b = '0;
		foreach (coord[i]) begin
			if (coord[i] < 0 || coord[i] > ONE_Q12) begin
				unit_all = 1'b0;
			end
			if (coord[i] <= ONE_Q12) begin
				above_all = 1'b0;
			end
		end
		if (obj < min_conf) begin
			return 1'b0;
		end
		if (mode == MODE_OBJ) begin
			if (!unit_all && !above_all) begin
				return 1'b0;
			end
			conf = longint'(obj);
			foreach (px[i]) begin
				px[i] = unit_all ? coord[i] * MODEL_SIZE_DEF : coord[i];
			end
		end else begin
			n = (class_count > MAX_CLASSES) ? MAX_CLASSES : int'(class_count);
			for (int j = 0; j < n; j++) begin
				if (longint'(score[j]) > best) begin
					best = longint'(score[j]);
					cls = CLS_W'(j);
				end
			end
			conf = (longint'(obj) * best) >> 15;
			if (conf > CONF_MAX) begin
				conf = CONF_MAX;
			end
			if (conf < longint'(min_conf)) begin
				return 1'b0;
			end
			if (mode == MODE_RANGE && !unit_all) begin
				return 1'b0;
			end
			foreach (px[i]) begin
				px[i] = coord[i] * MODEL_SIZE_DEF;
			end
		end
		if (!decode_axis(px[0], px[2], longint'(pad_x), longint'(image_width),
				b.left, b.width)) begin
			return 1'b0;
		end
		if (!decode_axis(px[1], px[3], longint'(pad_y), longint'(image_height),
				b.top, b.height)) begin
			return 1'b0;
		end
		b.conf = conf[CONF_W-1:0];
		b.cls = cls;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		box_t got;
		box_t want;
		longint coord[4];
		logic [SCORE_W-1:0] score[4];
		if (!arst_n) begin
			mode = MODE_CLASS;
			min_conf = RST_CONF_MIN;
			class_count = RST_CLASS_COUNT;
			inverse_scale = RST_INVERSE_SCALE;
			pad_x = RST_PAD;
			pad_y = RST_PAD;
			image_width = RST_IMAGE_SIZE;
			image_height = RST_IMAGE_SIZE;
			expected_boxes.delete();
			mismatches = 0;
		end else begin
			if (box_valid && box_ready) begin
				got = {left, top, rect_width, rect_height, confidence, best_class};
				if (expected_boxes.size() == 0) begin
					report("transaction with none expected, left", got.left, -1);
				end else begin
					want = expected_boxes.pop_front();
					if (got.left !== want.left) begin
						report("left", got.left, want.left);
					end
					if (got.top !== want.top) begin
						report("top", got.top, want.top);
					end
					if (got.width !== want.width) begin
						report("rect_width", got.width, want.width);
					end
					if (got.height !== want.height) begin
						report("rect_height", got.height, want.height);
					end
					if (got.conf !== want.conf) begin
						report("confidence", got.conf, want.conf);
					end
					if (got.cls !== want.cls) begin
						report("best_class", got.cls, want.cls);
					end
				end
			end
			if (pred_valid && pred_ready) begin
				coord[0] = longint'(x_center);
				coord[1] = longint'(y_center);
				coord[2] = longint'(box_width);
				coord[3] = longint'(box_height);
				score[0] = score_zero;
				score[1] = score_one;
				score[2] = score_two;
				score[3] = score_three;
				if (decode_prediction(coord, objectness, score, want)) begin
					expected_boxes.insert(expected_boxes.size(), want);
				end
			end
			if (cfg_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_MODE:          mode = cfg_data[MODE_W-1:0];
					REG_CONF_MIN:      min_conf = cfg_data[CONF_W-1:0];
					REG_CLASS_COUNT:   class_count = cfg_data[CNT_W-1:0];
					REG_INVERSE_SCALE: inverse_scale = cfg_data[INV_W-1:0];
					REG_PAD_X:         pad_x = cfg_data[PAD_W-1:0];
					REG_PAD_Y:         pad_y = cfg_data[PAD_W-1:0];
					REG_IMAGE_WIDTH:   image_width = cfg_data[PIX_W-1:0];
					REG_IMAGE_HEIGHT:  image_height = cfg_data[PIX_W-1:0];
					default: ;
				endcase
			end
		end
		boxes_owed = expected_boxes.size();
	end

endmodule

FILE: sim/detection_box_decoder_tb.sv
module detection_box_decoder_tb;
	import dbd_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = PIPE_STAGES + 6;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 115;
	localparam int SCORE_ONE    = 32768;
	localparam int COORD_MAX    = 8388607;
	localparam int COORD_MIN    = -8388608;

	typedef struct packed {
		logic [COORD_W-1:0]            xc;
		logic [COORD_W-1:0]            yc;
		logic [COORD_W-1:0]            bw;
		logic [COORD_W-1:0]            bh;
		logic [SCORE_W-1:0]            obj;
		logic [3:0][SCORE_W-1:0]       score;
	} pred_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CONF_W-1:0] thr;
		logic [CNT_W-1:0]  cc;
		logic [INV_W-1:0]  inv;
		logic [PAD_W-1:0]  px;
		logic [PAD_W-1:0]  py;
		logic [PIX_W-1:0]  iw;
		logic [PIX_W-1:0]  ih;
	} dec_settings_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_en;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       pred_valid;
	logic                       pred_ready;
	logic signed [COORD_W-1:0]  x_center;
	logic signed [COORD_W-1:0]  y_center;
	logic signed [COORD_W-1:0]  box_width;
	logic signed [COORD_W-1:0]  box_height;
	logic [SCORE_W-1:0]         objectness;
	logic [SCORE_W-1:0]         score_zero;
	logic [SCORE_W-1:0]         score_one;
	logic [SCORE_W-1:0]         score_two;
	logic [SCORE_W-1:0]         score_three;
	logic                       box_valid;
	logic                       box_ready = 1'b0;
	logic [PIX_W-1:0]           left;
	logic [PIX_W-1:0]           top;
	logic [PIX_W-1:0]           rect_width;
	logic [PIX_W-1:0]           rect_height;
	logic [CONF_W-1:0]          confidence;
	logic [CLS_W-1:0]           best_class;
	int                         mismatches;
	int                         boxes_owed;

	dec_settings_t dec_cfg;
	bit src_calm;
	bit sink_calm;
	bit box_taken;
	int sink_hold = 0;
	int quiet_cycles = 0;

	detection_box_decoder DUT (.*);

	dbd_box_checker box_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((pred_valid && pred_ready) || (box_valid && box_ready) || cfg_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 10));
	endfunction

	always @(posedge clk) box_taken <= box_valid && box_ready;

	always @(negedge clk) begin
		if (box_taken) begin
			sink_hold = draw_gap(sink_calm);
		end
		if (sink_hold > 0) begin
			box_ready <= 1'b0;
			sink_hold = sink_hold - 1;
		end else begin
			box_ready <= 1'b1;
		end
	end

	function automatic pred_t prediction(input int xc, input int yc, input int bw,
			input int bh, input int obj, input int s0, input int s1, input int s2,
			input int s3);
		pred_t p;
		p.xc = COORD_W'(xc);
		p.yc = COORD_W'(yc);
		p.bw = COORD_W'(bw);
		p.bh = COORD_W'(bh);
		p.obj = SCORE_W'(obj);
		p.score = {SCORE_W'(s3), SCORE_W'(s2), SCORE_W'(s1), SCORE_W'(s0)};
		return p;
	endfunction

	function automatic logic [SCORE_W-1:0] pick_score();
		int unsigned floor_v;
		floor_v = (dec_cfg.thr > SCORE_ONE) ? SCORE_ONE : dec_cfg.thr;
		if ($urandom_range(0, 99) < 85) begin
			return SCORE_W'($urandom_range(floor_v, SCORE_ONE));
		end
		return SCORE_W'($urandom_range(0, SCORE_ONE));
	endfunction

	function automatic logic [COORD_W-1:0] near_unit();
		return COORD_W'($urandom_range(0, ONE_Q12 + 128) - 64);
	endfunction

	function automatic pred_t random_pred();
		pred_t p;
		int kind;
		int best_k;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			p.xc = COORD_W'($urandom());
			p.yc = COORD_W'($urandom());
			p.bw = COORD_W'($urandom());
			p.bh = COORD_W'($urandom());
			p.obj = SCORE_W'($urandom_range(0, SCORE_ONE));
			for (int k = 0; k < 4; k++) begin
				p.score[k] = SCORE_W'($urandom_range(0, SCORE_ONE));
			end
			return p;
		end
		if (dec_cfg.mode == MODE_OBJ && kind < 45) begin
			// already in model pixels; a few mixed ones get dropped
			p.xc = COORD_W'($urandom_range(ONE_Q12 + 1, 700 * ONE_Q12));
			p.yc = COORD_W'($urandom_range(ONE_Q12 + 1, 700 * ONE_Q12));
			p.bw = COORD_W'($urandom_range(ONE_Q12 + 1, 300 * ONE_Q12));
			p.bh = COORD_W'($urandom_range(ONE_Q12 + 1, 300 * ONE_Q12));
			if (kind < 16) begin
				p.bw = COORD_W'($urandom_range(0, ONE_Q12));
			end
		end else if (kind < 30) begin
			p.xc = near_unit();
			p.yc = near_unit();
			p.bw = near_unit();
			p.bh = near_unit();
		end else begin
			p.xc = COORD_W'($urandom_range(0, ONE_Q12));
			p.yc = COORD_W'($urandom_range(0, ONE_Q12));
			p.bw = COORD_W'($urandom_range(0, ONE_Q12));
			p.bh = COORD_W'($urandom_range(0, ONE_Q12));
		end
		p.obj = pick_score();
		for (int k = 0; k < 4; k++) begin
			p.score[k] = SCORE_W'($urandom_range(0, SCORE_ONE));
		end
		best_k = $urandom_range(0, 3);
		p.score[best_k] = pick_score();
		if (kind % 7 == 0) begin
			p.score[(best_k + 1) % 4] = p.score[best_k];
		end
		return p;
	endfunction

	function automatic dec_settings_t phase_settings(input int ph);
		dec_settings_t s;
		case (ph)
			0: s = {MODE_CLASS, 16'd0, 3'd4, 24'd65536, 9'd0, 9'd0, 14'd640, 14'd640};
			1: s = {MODE_RANGE, 16'd32768, 3'd4, 24'hFFFFFF, 9'd320, 9'd320,
				14'd8192, 14'd8192};
			2: s = {MODE_OBJ, 16'd16384, 3'd1, 24'd1, 9'd0, 9'd0, 14'd1, 14'd1};
			3: s = {MODE_SPARE, 16'd0, 3'd0, 24'd65536, 9'd100, 9'd40,
				14'd1280, 14'd720};
			4: s = {MODE_CLASS, 16'd8000, 3'd7, 24'd98304, 9'd0, 9'd140,
				14'd1920, 14'd1080};
			default: begin
				s.mode = MODE_W'($urandom_range(MODE_CLASS, MODE_OBJ));
				s.thr = CONF_W'($urandom_range(0, 24000));
				s.cc = CNT_W'($urandom_range(1, MAX_CLASSES));
				s.inv = INV_W'($urandom_range(20000, 200000));
				s.px = PAD_W'($urandom_range(0, 320));
				s.py = PAD_W'($urandom_range(0, 320));
				s.iw = PIX_W'($urandom_range(16, 8192));
				s.ih = PIX_W'($urandom_range(16, 8192));
			end
		endcase
		return s;
	endfunction

	task automatic send(input pred_t p);
		int gap;
		gap = draw_gap(src_calm);
		@(negedge clk);
		if (gap > 0) begin
			pred_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pred_valid <= 1'b1;
		x_center <= p.xc;
		y_center <= p.yc;
		box_width <= p.bw;
		box_height <= p.bh;
		objectness <= p.obj;
		score_zero <= p.score[0];
		score_one <= p.score[1];
		score_two <= p.score[2];
		score_three <= p.score[3];
		@(posedge clk);
		while (!(pred_valid && pred_ready)) @(posedge clk);
	endtask

	// stop sending and let every owed box come out plus the dropped tail
	task automatic quiesce();
		@(negedge clk);
		pred_valid <= 1'b0;
		wait (boxes_owed == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
	endtask

	task automatic apply_settings(input dec_settings_t s);
		quiesce();
		write_reg(REG_MODE, CFG_DATA_W'(s.mode));
		write_reg(REG_CONF_MIN, CFG_DATA_W'(s.thr));
		write_reg(REG_CLASS_COUNT, CFG_DATA_W'(s.cc));
		write_reg(REG_INVERSE_SCALE, CFG_DATA_W'(s.inv));
		write_reg(REG_PAD_X, CFG_DATA_W'(s.px));
		write_reg(REG_PAD_Y, CFG_DATA_W'(s.py));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(s.iw));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(s.ih));
		@(negedge clk);
		cfg_en <= 1'b0;
		dec_cfg = s;
		src_calm = ($urandom_range(0, 2) == 0);
		sink_calm = ($urandom_range(0, 2) == 0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pred_valid = 1'b0;
		x_center = '0;
		y_center = '0;
		box_width = '0;
		box_height = '0;
		objectness = '0;
		score_zero = '0;
		score_one = '0;
		score_two = '0;
		score_three = '0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		dec_cfg = {MODE_CLASS, RST_CONF_MIN, RST_CLASS_COUNT, RST_INVERSE_SCALE,
			RST_PAD, RST_PAD, RST_IMAGE_SIZE, RST_IMAGE_SIZE};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: one class, half threshold
		send(prediction(2048, 2048, 2048, 2048, SCORE_ONE, SCORE_ONE, 0, 0, 0));
		send(prediction(2048, 2048, 2048, 2048, 16383, SCORE_ONE, 0, 0, 0));
		send(prediction(2048, 2048, 2048, 2048, 16384, SCORE_ONE, 0, 0, 0));
		send(prediction(2048, 2048, 2048, 2048, SCORE_ONE, 16383, 0, 0, 0));
		send(prediction(0, 0, ONE_Q12, ONE_Q12, SCORE_ONE, SCORE_ONE, 0, 0, 0));
		send(prediction(ONE_Q12, ONE_Q12, ONE_Q12, ONE_Q12, SCORE_ONE, SCORE_ONE, 0, 0, 0));
		send(prediction(2048, 2048, 0, 0, SCORE_ONE, SCORE_ONE, 0, 0, 0));
		send(prediction(2048, 2048, -ONE_Q12, 2048, SCORE_ONE, SCORE_ONE, 0, 0, 0));
		send(prediction(2048, 2048, 1, 1, SCORE_ONE, SCORE_ONE, 0, 0, 0));
		send(prediction(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, SCORE_ONE, SCORE_ONE,
			0, 0, 0));
		send(prediction(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SCORE_ONE, SCORE_ONE,
			0, 0, 0));
		send(prediction(2048, 2048, 2048, 2048, SCORE_ONE, 0, SCORE_ONE, SCORE_ONE,
			SCORE_ONE));
		send(prediction(-1, 4097, 2048, 2048, SCORE_ONE, SCORE_ONE, 0, 0, 0));

		// all classes, zero threshold: ties, last class best, zero confidence
		apply_settings({MODE_CLASS, 16'd0, 3'd4, RST_INVERSE_SCALE, 9'd0, 9'd0,
			14'd640, 14'd640});
		send(prediction(2048, 2048, 1024, 1024, SCORE_ONE, 20000, 20000, 100, 0));
		send(prediction(2048, 2048, 1024, 1024, SCORE_ONE, 100, 200, 300, SCORE_ONE));
		send(prediction(2048, 2048, 1024, 1024, SCORE_ONE, 0, 0, 0, 0));
		send(prediction(2048, 2048, 1024, 1024, 0, SCORE_ONE, 0, 0, 0));

		// range check
		apply_settings({MODE_RANGE, 16'd0, 3'd4, RST_INVERSE_SCALE, 9'd0, 9'd0,
			14'd640, 14'd640});
		send(prediction(ONE_Q12, ONE_Q12, ONE_Q12, ONE_Q12, SCORE_ONE, SCORE_ONE, 0, 0, 0));
		send(prediction(2048, 2048, 4097, 2048, SCORE_ONE, SCORE_ONE, 0, 0, 0));
		send(prediction(2048, -1, 2048, 2048, SCORE_ONE, SCORE_ONE, 0, 0, 0));

		// objectness only: normalized, model pixels, mixed
		apply_settings({MODE_OBJ, 16'd0, 3'd1, RST_INVERSE_SCALE, 9'd0, 9'd0,
			14'd640, 14'd640});
		send(prediction(2048, 2048, 2048, 2048, 12345, 0, 0, 0, 0));
		send(prediction(300 * ONE_Q12, 200 * ONE_Q12, 100 * ONE_Q12, 50 * ONE_Q12,
			SCORE_ONE, 0, 0, 0, 0));
		send(prediction(4097, 4097, 4097, 4097, SCORE_ONE, 0, 0, 0, 0));
		send(prediction(300 * ONE_Q12, 2048, 100 * ONE_Q12, 50 * ONE_Q12,
			SCORE_ONE, 0, 0, 0, 0));

		for (int ph = 0; ph < PHASES; ph++) begin
			apply_settings(phase_settings(ph));
			repeat (PHASE_ITEMS) send(random_pred());
		end

		quiesce();
		if (mismatches == 0 && boxes_owed == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: detection_box_decoder.f
hdl/dbd_pkg.sv
hdl/dbd_axis.sv
hdl/dbd_score.sv
hdl/detection_box_decoder.sv
sim/dbd_box_checker.sv
sim/detection_box_decoder_tb.sv
